/* sv/cqd_pkg.sv */
// Package: shared constants and helpers of the CSV quote-aware deframer.
`default_nettype none
package cqd_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_COUNT_WIDTH = 32;
	localparam int ADDR_WIDTH = 3;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] DELIM_RESET = 8'h2C;
	localparam logic [7:0] QUOTE_RESET = 8'h22;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [OUT_COUNT_WIDTH-1:0] out_count_t;

	typedef enum logic {
		REG_DELIM = 1'b0,
		REG_QUOTE = 1'b1
	} reg_idx_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : count_t'(v + count_t'(1));
	endfunction

	// clamp a counter to the output width
	function automatic out_count_t out_count(input count_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'(out_count_t'('1))) ? out_count_t'('1) : out_count_t'(w);
	endfunction

endpackage
`default_nettype wire

/* sv/cqd_if.sv */
// Interfaces: raw byte channel and classified byte channel.
`default_nettype none
interface cqd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       flush;

	modport source (output valid, data_byte, flush, input ready);
	modport sink   (input valid, data_byte, flush, output ready);
endinterface

interface cqd_class_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        keep;
	logic        field_end;
	logic        record_end;
	logic        last;
	logic [31:0] field_count;
	logic [31:0] record_count;

	modport source (output valid, out_byte, byte_valid, keep, field_end, record_end, last,
		field_count, record_count, input ready);
	modport sink   (input valid, out_byte, byte_valid, keep, field_end, record_end, last,
		field_count, record_count, output ready);
endinterface
`default_nettype wire

/* sv/csv_quote_aware_deframer.sv */
// Top level: CSV quote-aware deframer.
//
// csv carries raw CSV bytes with a flush flag marking end of input; cls carries
// one classification per byte (keep/delete, field and record ends, running
// counts). Each byte is reported one transaction late, when the following byte
// arrives, since a closing quote is resolved by its successor. The first byte
// of a stream gives no result; a flush transaction always gives exactly one
// result with last set, and clears the stream state and counts.
// A transaction on csv produces its result in the cls register at the next
// clock edge; one byte per cycle is sustained while cls is ready. The single
// per-byte state update (quote tracking, counters) sets that rate.
// If cls stalls, csv.ready stays high only when the result register is free
// or being emptied in the same cycle; nothing is dropped.
// Reset (arst_n low) clears the stream state, counts and output valid, and sets
// delimiter to comma, quote to double quote. The user writes delimiter
// (address 0) and quote (address 4) over APB only while idle; it goes unchecked.
`default_nettype none
module csv_quote_aware_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cqd_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	cqd_byte_if.sink                           csv,
	cqd_class_if.source                        cls
);
	import cqd_pkg::*;

	logic [7:0] delim_q;
	logic [7:0] quote_q;

	logic       inside_q;
	logic       pending_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	count_t     field_total_q;
	count_t     record_total_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       keep_q;
	logic       field_end_q;
	logic       record_end_q;
	logic       last_q;
	out_count_t field_count_q;
	out_count_t record_count_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	logic     accept;
	logic     produce;
	logic     next_quote;
	logic     h_quote, h_delim, h_lf, h_cr;
	logic     c_keep, c_fend, c_rend, c_inside, c_pending;
	count_t   c_field, c_record;

	// APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		case (cfg_idx)
			REG_DELIM: prdata = {24'b0, delim_q};
			REG_QUOTE: prdata = {24'b0, quote_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DELIM: delim_q <= pwdata[7:0];
				REG_QUOTE: quote_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// classify the held byte
	assign csv.ready  = !out_valid_q || cls.ready;
	assign accept     = csv.valid && csv.ready;
	assign produce    = csv.flush || held_valid_q;
	assign next_quote = !csv.flush && (csv.data_byte == quote_q);

	assign h_quote = (held_byte_q == quote_q);
	assign h_delim = (held_byte_q == delim_q);
	assign h_lf    = (held_byte_q == BYTE_LF);
	assign h_cr    = (held_byte_q == BYTE_CR);

	always_comb begin
		c_inside  = inside_q;
		c_pending = 1'b0;
		c_fend    = 1'b0;
		c_rend    = 1'b0;
		if (h_quote) begin
			if (!inside_q) begin
				c_keep   = pending_q;
				c_inside = 1'b1;
			end else begin
				c_keep    = 1'b0;
				c_inside  = 1'b0;
				c_pending = next_quote;
			end
		end else begin
			c_keep = !h_cr && !(h_delim && !inside_q);
			c_fend = (h_delim || h_lf) && !inside_q;
			c_rend = h_lf && !inside_q;
		end
		c_field  = c_fend ? sat_inc(field_total_q) : field_total_q;
		c_record = c_rend ? sat_inc(record_total_q) : record_total_q;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q       <= 1'b0;
			pending_q      <= 1'b0;
			held_valid_q   <= 1'b0;
			field_total_q  <= '0;
			record_total_q <= '0;
		end else if (accept) begin
			if (csv.flush) begin
				inside_q       <= 1'b0;
				pending_q      <= 1'b0;
				held_valid_q   <= 1'b0;
				field_total_q  <= '0;
				record_total_q <= '0;
			end else begin
				held_valid_q <= 1'b1;
				if (held_valid_q) begin
					inside_q       <= c_inside;
					pending_q      <= c_pending;
					field_total_q  <= c_field;
					record_total_q <= c_record;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !csv.flush)
			held_byte_q <= csv.data_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= produce;
		else if (cls.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			last_q         <= csv.flush;
			byte_valid_q   <= held_valid_q;
			out_byte_q     <= held_valid_q ? held_byte_q : 8'h00;
			keep_q         <= held_valid_q && c_keep;
			field_end_q    <= held_valid_q && c_fend;
			record_end_q   <= held_valid_q && c_rend;
			field_count_q  <= out_count(held_valid_q ? c_field : field_total_q);
			record_count_q <= out_count(held_valid_q ? c_record : record_total_q);
		end
	end

	assign cls.valid        = out_valid_q;
	assign cls.out_byte     = out_byte_q;
	assign cls.byte_valid   = byte_valid_q;
	assign cls.keep         = keep_q;
	assign cls.field_end    = field_end_q;
	assign cls.record_end   = record_end_q;
	assign cls.last         = last_q;
	assign cls.field_count  = field_count_q;
	assign cls.record_count = record_count_q;

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && csv.flush |=> !held_valid_q && field_total_q == '0 && !inside_q)
		else $error("flush did not clear stream state");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !csv.flush |=> held_valid_q)
		else $error("accepted byte not held");

	a_counts_order: assert property (@(posedge clk) disable iff (!arst_n)
		record_total_q <= field_total_q)
		else $error("record count exceeds field count");

	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cls.valid && !cls.byte_valid |-> cls.last && !cls.keep && !cls.field_end)
		else $error("byteless result that is not an empty flush");

endmodule
`default_nettype wire

/* tb/csv_quote_aware_deframer_test.sv */
// Testbench: CSV quote-aware deframer, with its own classifier model and a result scoreboard.
module csv_quote_aware_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cqd_pkg::*;

	localparam int STALL_LIMIT = 500;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       keep;
		logic       field_end;
		logic       record_end;
		logic       last;
		out_count_t field_count;
		out_count_t record_count;
	} class_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	cqd_byte_if  csv_ch();
	cqd_class_if cls_ch();

	csv_quote_aware_deframer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.csv     (csv_ch),
		.cls     (cls_ch)
	);

	// classifier model state
	logic [7:0] delim_q;
	logic [7:0] quote_q;
	logic       quoted;
	logic       esc_next;
	logic [7:0] held;
	logic       held_ok;
	count_t     n_fields;
	count_t     n_records;

	class_result_t expected_cls[$];
	class_result_t exp_r;
	int            errors;
	int            item_count;
	int            stall_left;
	int            idle_cycles;
	bit            idle_on;
	bit            csv_driving;

	always #6 clk = ~clk;

	function automatic count_t bump(input count_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic clear_stream;
		quoted = 1'b0;
		esc_next = 1'b0;
		held = 8'h00;
		held_ok = 1'b0;
		n_fields = '0;
		n_records = '0;
	endtask

	// resolve the held byte; next_is_quote is the lookahead
	task automatic classify_held(input logic next_is_quote, output class_result_t r);
		logic k;
		logic fe;
		logic re;
		logic nxt;
		fe = 1'b0;
		re = 1'b0;
		nxt = 1'b0;
		if (held == quote_q) begin
			if (!quoted) begin
				k = esc_next;
				quoted = 1'b1;
			end else begin
				k = 1'b0;
				quoted = 1'b0;
				nxt = next_is_quote;
			end
		end else begin
			k = (held != BYTE_CR) && !((held == delim_q) && !quoted);
			fe = ((held == delim_q) || (held == BYTE_LF)) && !quoted;
			re = (held == BYTE_LF) && !quoted;
		end
		esc_next = nxt;
		if (fe)
			n_fields = bump(n_fields);
		if (re)
			n_records = bump(n_records);
		r = '{held, 1'b1, k, fe, re, 1'b0, n_fields, n_records};
	endtask

	task automatic predict_item(input logic [7:0] b, input logic fl);
		class_result_t r;
		if (fl) begin
			if (held_ok)
				classify_held(1'b0, r);
			else
				r = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, n_fields, n_records};
			r.last = 1'b1;
			expected_cls.push_back(r);
			clear_stream();
		end else begin
			if (held_ok) begin
				classify_held(b == quote_q, r);
				expected_cls.push_back(r);
			end
			held = b;
			held_ok = 1'b1;
		end
	endtask

	task automatic csv_release;
		if (csv_driving) begin
			csv_ch.valid <= 1'b0;
			csv_driving = 1'b0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fl);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			csv_release();
			repeat (gap) @(posedge clk);
		end
		csv_ch.valid <= 1'b1;
		csv_ch.data_byte <= b;
		csv_ch.flush <= fl;
		csv_driving = 1'b1;
		do @(posedge clk); while (!csv_ch.ready);
		predict_item(b, fl);
		item_count++;
	endtask

	task automatic push_flush;
		push_byte(8'($urandom), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	// hold the sender until every expected transaction is back
	task automatic drain;
		csv_release();
		while (expected_cls.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [7:0] v);
		logic [31:0] word;
		word = $urandom;
		word[7:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WIDTH'({idx, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_DELIM)
			delim_q = v;
		else
			quote_q = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== v) begin
			$error("prdata: expected %0h, got %0h", v, prdata[7:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_chars(input logic [7:0] d, input logic [7:0] q);
		apb_write(REG_DELIM, d);
		apb_write(REG_QUOTE, q);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = 8'($urandom);
			else
				b = 8'(8'h61 + $urandom_range(0, 25));
		end while (b == quote_q);
		return b;
	endfunction

	task automatic send_record;
		int n_cols;
		int len;
		n_cols = $urandom_range(1, 4);
		for (int c = 0; c < n_cols; c++) begin
			if (c > 0)
				push_byte(delim_q, 1'b0);
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 2) == 0) begin
				push_byte(quote_q, 1'b0);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 7))
						0: begin
							push_byte(quote_q, 1'b0);
							push_byte(quote_q, 1'b0);
						end
						1: push_byte(delim_q, 1'b0);
						2: push_byte(BYTE_LF, 1'b0);
						3: push_byte(BYTE_CR, 1'b0);
						default: push_byte(text_byte(), 1'b0);
					endcase
				end
				push_byte(quote_q, 1'b0);
			end else begin
				for (int k = 0; k < len; k++)
					push_byte(text_byte(), 1'b0);
			end
		end
		if ($urandom_range(0, 1) == 0)
			push_byte(BYTE_CR, 1'b0);
		push_byte(BYTE_LF, 1'b0);
	endtask

	task automatic send_noise;
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0: push_byte(quote_q, 1'b0);
				1: push_byte(delim_q, 1'b0);
				2: push_byte(BYTE_LF, 1'b0);
				3: push_byte(BYTE_CR, 1'b0);
				default: push_byte(8'($urandom), 1'b0);
			endcase
		end
	endtask

	task automatic test_directed;
		push_flush();
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		send_text("a,\"x\"\"y,\n\"\015\n");
		push_flush();
		send_text("\"q\"");
		push_flush();
		send_text("\"u,");
		push_flush();
		drain();
	endtask

	task automatic test_overlapping_chars;
		set_chars(BYTE_LF, QUOTE_RESET);
		send_text("a\nb\"\n\"\n");
		push_flush();
		drain();
		set_chars(BYTE_CR, 8'h2C);
		send_text("x\015,y,,\015\n,");
		push_flush();
		drain();
		set_chars(8'h00, 8'h00);
		push_byte(8'h00, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(BYTE_LF, 1'b0);
		push_flush();
		drain();
		set_chars(8'hFF, 8'h00);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_flush();
		drain();
	endtask

	task automatic test_random_streams;
		int stop_at;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_chars(DELIM_RESET, QUOTE_RESET);
				1: set_chars(8'h00, 8'hFF);
				2: set_chars(8'hFF, 8'h00);
				default: set_chars(8'($urandom), 8'($urandom));
			endcase
			idle_on = (ph != 3);
			stop_at = item_count + 250;
			while (item_count < stop_at) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_record();
				if ($urandom_range(0, 7) == 0)
					push_flush();
				if ($urandom_range(0, 29) == 0)
					drain();
			end
			push_flush();
			drain();
		end
		idle_on = 1'b1;
	endtask

	// result side: random stall after each transaction, while idle_on is set
	always @(posedge clk) begin
		if (cls_ch.valid && cls_ch.ready) begin
			stall_left = idle_on ? $urandom_range(0, 15) : 0;
			cls_ch.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				cls_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cls_ch.valid && cls_ch.ready) begin
			if (expected_cls.size() == 0) begin
				$error("unexpected result transaction, out_byte %0h", cls_ch.out_byte);
				errors++;
			end else begin
				exp_r = expected_cls.pop_front();
				if (cls_ch.out_byte !== exp_r.out_byte) begin
					$error("out_byte: expected %0h, got %0h", exp_r.out_byte, cls_ch.out_byte);
					errors++;
				end
				if (cls_ch.byte_valid !== exp_r.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b", exp_r.byte_valid,
						cls_ch.byte_valid);
					errors++;
				end
				if (cls_ch.keep !== exp_r.keep) begin
					$error("keep: expected %0b, got %0b", exp_r.keep, cls_ch.keep);
					errors++;
				end
				if (cls_ch.field_end !== exp_r.field_end) begin
					$error("field_end: expected %0b, got %0b", exp_r.field_end,
						cls_ch.field_end);
					errors++;
				end
				if (cls_ch.record_end !== exp_r.record_end) begin
					$error("record_end: expected %0b, got %0b", exp_r.record_end,
						cls_ch.record_end);
					errors++;
				end
				if (cls_ch.last !== exp_r.last) begin
					$error("last: expected %0b, got %0b", exp_r.last, cls_ch.last);
					errors++;
				end
				if (cls_ch.field_count !== exp_r.field_count) begin
					$error("field_count: expected %0d, got %0d", exp_r.field_count,
						cls_ch.field_count);
					errors++;
				end
				if (cls_ch.record_count !== exp_r.record_count) begin
					$error("record_count: expected %0d, got %0d", exp_r.record_count,
						cls_ch.record_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (csv_ch.valid && csv_ch.ready) || (cls_ch.valid && cls_ch.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		csv_ch.valid = 1'b0;
		csv_ch.data_byte = 8'h00;
		csv_ch.flush = 1'b0;
		cls_ch.ready = 1'b0;
		stall_left = 1;
		idle_cycles = 0;
		errors = 0;
		item_count = 0;
		idle_on = 1'b1;
		csv_driving = 1'b0;
		delim_q = DELIM_RESET;
		quote_q = QUOTE_RESET;
		clear_stream();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overlapping_chars();
		test_random_streams();
		drain();

		if (expected_cls.size() != 0) begin
			$error("%0d result transactions never arrived", expected_cls.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
